>>> design/pfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page fault frame replacer.
// No dependencies; used by every module of the block.
package pfr_pkg;

	localparam int DEF_FRAMES = 64;

	localparam int PAGE_W  = 10;
	localparam int BITS_W  = 2;
	localparam int FRAME_W = 6;
	localparam int CNT_W   = 32;

	// victim LFSR and the remainder unit that reduces it
	localparam int          LFSR_W    = 32;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam int          MOD_BPC   = 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FIU_W      = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED   = 2'd2;

	localparam logic POL_RANDOM = 1'b0;
	localparam logic POL_FIFO   = 1'b1;

	// protection codes
	localparam logic [BITS_W-1:0] BITS_NONE       = 2'd0;
	localparam logic [BITS_W-1:0] BITS_READ       = 2'd1;
	localparam logic [BITS_W-1:0] BITS_WRITE_ONLY = 2'd2;
	localparam logic [BITS_W-1:0] BITS_RW         = 2'd3;

	localparam logic ST_HANDLED = 1'b0;
	localparam logic ST_BAD     = 1'b1;

	typedef struct packed {
		logic [PAGE_W-1:0]  page;
		logic [BITS_W-1:0]  current_bits;
		logic [FRAME_W-1:0] current_frame;
	} in_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [BITS_W-1:0]  new_bits;
		logic               read_from_disk;
		logic               evicted;
		logic [PAGE_W-1:0]  evicted_page;
		logic               write_back;
		logic               status;
		logic [CNT_W-1:0]   fault_count;
		logic [CNT_W-1:0]   read_count;
		logic [CNT_W-1:0]   write_count;
		logic [CNT_W-1:0]   invalidate_count;
	} out_t;

	// one frame table entry
	typedef struct packed {
		logic              writable;
		logic [PAGE_W-1:0] page;
	} entry_t;

endpackage

>>> design/page_fault_frame_replacer_core.sv
`timescale 1ns / 1ps
// Fills, upgrades and bad bits are decided in S_DECIDE and the result registered;
// a FIFO eviction goes on through S_READ (frame table read) and S_EVICT; a random
// eviction first runs S_DIVIDE (4-bit-per-cycle remainder unit), then S_READ, S_EVICT.
// One item in flight: the next is taken once the result loads; output stall holds it.
// Reset clears control, counters and the LFSR (to 1); the frame table is not
// cleared: an entry is only read on eviction, after it has been filled.
module page_fault_frame_replacer_core #(
	parameter int FRAMES = pfr_pkg::DEF_FRAMES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  pfr_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pfr_pkg::out_t                  out_data,
	input  logic                           cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);
	localparam int CW = (NW > pfr_pkg::FIU_W) ? NW : pfr_pkg::FIU_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_DIVIDE,
		S_READ,
		S_EVICT
	} state_t;

	state_t                            state_q;
	pfr_pkg::in_t                      item_q;
	logic                              policy_q;
	logic [pfr_pkg::FIU_W-1:0]         fiu_q;
	logic [pfr_pkg::LFSR_W-1:0]        lfsr_q;
	logic [NW-1:0]                     filled_q;
	logic [FW-1:0]                     ptr_q;
	logic [FW-1:0]                     victim_q;
	logic [pfr_pkg::CNT_W-1:0]         faults_q, reads_q, writes_q, invals_q;
	logic                              out_valid_q;
	logic [pfr_pkg::FRAME_W-1:0]       res_frame_q;
	logic [pfr_pkg::BITS_W-1:0]        res_bits_q;
	logic                              res_rd_q, res_ev_q, res_wb_q, res_st_q;
	logic [pfr_pkg::PAGE_W-1:0]        res_evp_q;

	logic [CW-1:0]                     n_c;
	logic [NW-1:0]                     n;
	logic                              fill_ok;
	logic [FW-1:0]                     ptr_eff;
	logic [NW-1:0]                     ptr_inc;
	logic [FW-1:0]                     ptr_next;
	logic [pfr_pkg::LFSR_W-1:0]        lfsr_next;
	logic [pfr_pkg::LFSR_W-1:0]        seed_val;
	logic                              out_free;
	logic                              immediate;
	logic                              emit;
	logic                              cur_in_range;
	logic                              mem_we;
	logic [FW-1:0]                     mem_waddr;
	pfr_pkg::entry_t                   mem_wdata;
	pfr_pkg::entry_t                   mem_rdata;
	logic                              mod_start;
	logic                              mod_done;
	logic [FW-1:0]                     mod_rem;
	logic [pfr_pkg::FRAME_W-1:0]       res_frame;
	logic [pfr_pkg::BITS_W-1:0]        res_bits;
	logic                              res_rd, res_ev, res_wb, res_st;
	logic [pfr_pkg::PAGE_W-1:0]        res_evp;

	// effective frame count: 0 acts as 1, above FRAMES clamps to FRAMES
	always_comb begin
		if (fiu_q == '0) begin
			n_c = CW'(1);
		end else if (CW'(fiu_q) > CW'(FRAMES)) begin
			n_c = CW'(FRAMES);
		end else begin
			n_c = CW'(fiu_q);
		end
		n = n_c[NW-1:0];
	end

	assign fill_ok   = filled_q < n;
	assign ptr_eff   = (NW'(ptr_q) >= n) ? '0 : ptr_q;
	assign ptr_inc   = NW'(ptr_eff) + 1'b1;
	assign ptr_next  = (ptr_inc >= n) ? '0 : ptr_inc[FW-1:0];
	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? pfr_pkg::LFSR_MASK : '0);
	assign seed_val  = (cfg_data == '0) ? pfr_pkg::LFSR_W'(1) : cfg_data;
	assign out_free  = !out_valid_q || !out_stall;
	assign immediate = (item_q.current_bits != pfr_pkg::BITS_NONE) || fill_ok;
	assign emit      = out_free && (((state_q == S_DECIDE) && immediate) ||
		(state_q == S_EVICT));
	assign cur_in_range = 32'(item_q.current_frame) < 32'(FRAMES);
	assign mod_start = (state_q == S_DECIDE) && !immediate &&
		(policy_q == pfr_pkg::POL_RANDOM);
	assign in_stall  = (state_q != S_IDLE);

	// result fields and the frame table write that goes with them
	always_comb begin
		res_frame      = item_q.current_frame;
		res_bits       = item_q.current_bits;
		res_rd         = 1'b0;
		res_ev         = 1'b0;
		res_evp        = '0;
		res_wb         = 1'b0;
		res_st         = pfr_pkg::ST_HANDLED;
		mem_we         = 1'b0;
		mem_waddr      = FW'(item_q.current_frame);
		mem_wdata.page = item_q.page;
		mem_wdata.writable = 1'b0;
		if (state_q == S_EVICT) begin
			res_frame = pfr_pkg::FRAME_W'(victim_q);
			res_bits  = pfr_pkg::BITS_READ;
			res_rd    = 1'b1;
			res_ev    = 1'b1;
			res_evp   = mem_rdata.page;
			res_wb    = mem_rdata.writable;
			mem_we    = emit;
			mem_waddr = victim_q;
		end else begin
			case (item_q.current_bits) inside
				pfr_pkg::BITS_NONE: begin
					res_frame = pfr_pkg::FRAME_W'(filled_q[FW-1:0]);
					res_bits  = pfr_pkg::BITS_READ;
					res_rd    = 1'b1;
					mem_we    = emit;
					mem_waddr = filled_q[FW-1:0];
				end
				pfr_pkg::BITS_WRITE_ONLY: begin
					res_st = pfr_pkg::ST_BAD;
				end
				pfr_pkg::BITS_READ, pfr_pkg::BITS_RW: begin
					res_bits = pfr_pkg::BITS_RW;
					mem_we   = emit && cur_in_range;
					mem_wdata.writable = 1'b1;
				end
				default: begin
					res_st = pfr_pkg::ST_BAD;
				end
			endcase
		end
	end

	pfr_frame_mem #(.FRAMES(FRAMES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (victim_q),
		.rdata (mem_rdata)
	);

	pfr_mod_unit #(.FRAMES(FRAMES)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (lfsr_next),
		.divisor   (n),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= pfr_pkg::POL_FIFO;
			fiu_q       <= pfr_pkg::FIU_W'(64);
			lfsr_q      <= pfr_pkg::LFSR_W'(1);
			filled_q    <= '0;
			ptr_q       <= '0;
			victim_q    <= '0;
			faults_q    <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
			invals_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfr_pkg::CFG_POLICY:        policy_q <= cfg_data[0];
					pfr_pkg::CFG_FRAMES_IN_USE: fiu_q <= cfg_data[pfr_pkg::FIU_W-1:0];
					pfr_pkg::CFG_RANDOM_SEED:   lfsr_q <= seed_val;
					default: ;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!immediate) begin
						if (policy_q == pfr_pkg::POL_FIFO) begin
							victim_q <= ptr_eff;
							ptr_q    <= ptr_next;
							state_q  <= S_READ;
						end else begin
							lfsr_q  <= lfsr_next;
							state_q <= S_DIVIDE;
						end
					end else if (out_free) begin
						if (item_q.current_bits == pfr_pkg::BITS_NONE) begin
							filled_q <= filled_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_DIVIDE: begin
					if (mod_done) begin
						victim_q <= mod_rem;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVICT;
				end
				S_EVICT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				faults_q <= faults_q + 1'b1;
				if (res_rd) begin
					reads_q <= reads_q + 1'b1;
				end
				if (res_wb) begin
					writes_q <= writes_q + 1'b1;
				end
				if (res_ev) begin
					invals_q <= invals_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_data;
		end
		if (emit) begin
			res_frame_q <= res_frame;
			res_bits_q  <= res_bits;
			res_rd_q    <= res_rd;
			res_ev_q    <= res_ev;
			res_evp_q   <= res_evp;
			res_wb_q    <= res_wb;
			res_st_q    <= res_st;
		end
	end

	// counters only move when a new result loads, so they track the shown item
	always_comb begin
		out_data.frame            = res_frame_q;
		out_data.new_bits         = res_bits_q;
		out_data.read_from_disk   = res_rd_q;
		out_data.evicted          = res_ev_q;
		out_data.evicted_page     = res_evp_q;
		out_data.write_back       = res_wb_q;
		out_data.status           = res_st_q;
		out_data.fault_count      = faults_q;
		out_data.read_count       = reads_q;
		out_data.write_count      = writes_q;
		out_data.invalidate_count = invals_q;
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("victim LFSR reached zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVICT |-> NW'(victim_q) < n)
		else $error("victim frame beyond active frame count");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(filled_q) <= 32'(FRAMES))
		else $error("fill count beyond frame table depth");
`endif

endmodule

>>> design/pfr_frame_mem.sv
`timescale 1ns / 1ps
// Frame table: resident page and write permission per frame.
// Single write port, one registered read port. Uses pfr_pkg.
module pfr_frame_mem #(
	parameter int FRAMES = pfr_pkg::DEF_FRAMES,
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [FW-1:0]   waddr,
	input  pfr_pkg::entry_t wdata,
	input  logic [FW-1:0]   raddr,
	output pfr_pkg::entry_t rdata
);

	pfr_pkg::entry_t mem [FRAMES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/pfr_mod_unit.sv
`timescale 1ns / 1ps
// Iterative remainder unit: dividend mod divisor, MOD_BPC bits per cycle.
// Divisor is at most FRAMES. Uses pfr_pkg.
module pfr_mod_unit #(
	parameter int FRAMES = pfr_pkg::DEF_FRAMES,
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int NW = $clog2(FRAMES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pfr_pkg::LFSR_W-1:0] dividend,
	input  logic [NW-1:0]              divisor,
	output logic                       done,
	output logic [FW-1:0]              remainder
);

	localparam int STEPS = pfr_pkg::LFSR_W / pfr_pkg::MOD_BPC;
	localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                       run_q;
	logic [SC_W-1:0]            step_q;
	logic [pfr_pkg::LFSR_W-1:0] div_q;
	logic [FW-1:0]              rem_q;
	logic [FW:0]                dsr_q;
	logic [FW-1:0]              r;
	logic [FW:0]                t;

	// restoring remainder, MOD_BPC dividend bits per cycle; partial stays below divisor
	always_comb begin
		r = rem_q;
		t = '0;
		for (int i = 0; i < pfr_pkg::MOD_BPC; i++) begin
			t = {r, div_q[pfr_pkg::LFSR_W-1-i]};
			if (t >= dsr_q) begin
				t = t - dsr_q;
			end
			r = t[FW-1:0];
		end
	end

	assign done      = run_q && (step_q == SC_W'(STEPS - 1));
	assign remainder = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
			dsr_q <= (FW + 1)'(divisor);
		end else if (run_q) begin
			div_q <= div_q << pfr_pkg::MOD_BPC;
			rem_q <= r;
		end
	end

endmodule

>>> bench/page_fault_frame_replacer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for page_fault_frame_replacer_core: directed faults, then random phases.
// Depends on pfr_pkg and the core; every result is checked against a local frame tracker.
module page_fault_frame_replacer_core_tb;
	import pfr_pkg::*;

	localparam int NFR        = DEF_FRAMES;
	localparam int CYCLE_CAP  = 200000;
	localparam int PHASES     = 8;
	localparam int PER_PHASE  = 62;

	typedef enum logic {ROW_FAULT, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		int                 a;      // page, or register index
		logic [31:0]        b;      // protection bits, or register value
		int                 c;      // current frame
		bit                 pin;
		logic [FRAME_W-1:0] frame;
		logic [BITS_W-1:0]  nbits;
		logic               st;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// frame tracker state
	logic [PAGE_W-1:0] held_page [NFR];
	bit                held_rw [NFR];
	int unsigned       filled;
	int unsigned       vptr;
	logic [31:0]       lfsr;
	logic [31:0]       n_faults, n_reads, n_writes, n_invals;
	logic              cur_policy;
	logic [FIU_W-1:0]  cur_frames;

	out_t  replies_due [$];
	row_t  plan [$];
	int    mismatches;
	int    cycles;
	bit    calm;

	page_fault_frame_replacer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned frames_now();
		if (cur_frames == 0)
			return 1;
		if (cur_frames > NFR)
			return NFR;
		return cur_frames;
	endfunction

	// frame the core must hand out for one fault, with updated tallies
	function automatic out_t resolve_fault(in_t f);
		out_t r;
		int unsigned n;
		logic [FRAME_W-1:0] fr;
		logic lsb;
		r = '0;
		r.frame = f.current_frame;
		r.new_bits = f.current_bits;
		r.status = ST_HANDLED;
		n_faults++;
		case (f.current_bits)
			BITS_NONE: begin
				n = frames_now();
				if (filled < n) begin
					fr = filled[FRAME_W-1:0];
					filled++;
				end else begin
					if (cur_policy == POL_FIFO) begin
						if (vptr >= n)
							vptr = 0;
						fr = vptr[FRAME_W-1:0];
						vptr = (vptr + 1 >= n) ? 0 : vptr + 1;
					end else begin
						lsb = lfsr[0];
						lfsr = lfsr >> 1;
						if (lsb)
							lfsr ^= LFSR_MASK;
						fr = FRAME_W'(lfsr % n);
					end
					r.evicted = 1'b1;
					r.evicted_page = held_page[fr];
					r.write_back = held_rw[fr];
					if (held_rw[fr])
						n_writes++;
					n_invals++;
				end
				held_page[fr] = f.page;
				held_rw[fr] = 1'b0;
				r.frame = fr;
				r.new_bits = BITS_READ;
				r.read_from_disk = 1'b1;
				n_reads++;
			end
			BITS_WRITE_ONLY: begin
				r.status = ST_BAD;
			end
			default: begin
				// read-only or already read/write: upgrade in place
				r.new_bits = BITS_RW;
				held_page[f.current_frame] = f.page;
				held_rw[f.current_frame] = 1'b1;
			end
		endcase
		r.fault_count = n_faults;
		r.read_count = n_reads;
		r.write_count = n_writes;
		r.invalidate_count = n_invals;
		return r;
	endfunction

	function automatic row_t row(row_kind_t k, int a, logic [31:0] b, int c, bit pin,
		logic [FRAME_W-1:0] fr, logic [BITS_W-1:0] nb, logic st);
		row_t r;
		r.kind = k;
		r.a = a;
		r.b = b;
		r.c = c;
		r.pin = pin;
		r.frame = fr;
		r.nbits = nb;
		r.st = st;
		return r;
	endfunction

	function automatic in_t random_fault();
		in_t f;
		int pick;
		pick = $urandom_range(0, 99);
		f.page = PAGE_W'($urandom_range(0, 1023));
		f.current_frame = FRAME_W'($urandom_range(0, 63));
		if (pick < 60)
			f.current_bits = BITS_NONE;
		else if (pick < 75)
			f.current_bits = BITS_READ;
		else if (pick < 85)
			f.current_bits = BITS_RW;
		else if (pick < 92)
			f.current_bits = BITS_WRITE_ONLY;
		else
			f.current_bits = BITS_W'($urandom_range(0, 3));
		// upgrades mostly hit frames the core manages
		if (f.current_bits != BITS_NONE && $urandom_range(0, 1))
			f.current_frame = FRAME_W'($urandom_range(0, frames_now() - 1));
		return f;
	endfunction

	task automatic settle_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		settle_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_POLICY: cur_policy = val[0];
			CFG_FRAMES_IN_USE: cur_frames = val[FIU_W-1:0];
			CFG_RANDOM_SEED: lfsr = (val == 0) ? 32'd1 : val;
			default: ;
		endcase
	endtask

	task automatic offer_fault(in_t f, bit pin, logic [FRAME_W-1:0] fr,
		logic [BITS_W-1:0] nb, logic st);
		out_t e;
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		in_data = f;
		do @(posedge clk); while (in_stall !== 1'b0);
		e = resolve_fault(f);
		if (pin) begin
			e.frame = fr;
			e.new_bits = nb;
			e.status = st;
		end
		replies_due.push_back(e);
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic void tell(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random stall before each item
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 8);
			repeat (n) @(negedge clk) out_stall = 1'b1;
			@(negedge clk) out_stall = 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (replies_due.size() == 0) begin
				$error("result item with nothing pending, frame %0d", out_data.frame);
				mismatches++;
			end else begin
				e = replies_due.pop_front();
				tell("frame", e.frame, out_data.frame);
				tell("new_bits", e.new_bits, out_data.new_bits);
				tell("read_from_disk", e.read_from_disk, out_data.read_from_disk);
				tell("evicted", e.evicted, out_data.evicted);
				tell("evicted_page", e.evicted_page, out_data.evicted_page);
				tell("write_back", e.write_back, out_data.write_back);
				tell("status", e.status, out_data.status);
				tell("fault_count", e.fault_count, out_data.fault_count);
				tell("read_count", e.read_count, out_data.read_count);
				tell("write_count", e.write_count, out_data.write_count);
				tell("invalidate_count", e.invalidate_count, out_data.invalidate_count);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		in_t f;
		int frames_pick [PHASES];
		logic [31:0] seed_pick [PHASES];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_POLICY;
		cfg_data = '0;
		calm = 1'b0;
		mismatches = 0;
		cycles = 0;
		foreach (held_page[i]) begin
			held_page[i] = '0;
			held_rw[i] = 1'b0;
		end
		filled = 0;
		vptr = 0;
		lfsr = 32'd1;
		n_faults = 0;
		n_reads = 0;
		n_writes = 0;
		n_invals = 0;
		cur_policy = POL_FIFO;
		cur_frames = FIU_W'(NFR);

		// fills from reset, bad bits, upgrades, FIFO wrap, frame count limits, random victims
		plan.push_back(row(ROW_FAULT, 0, BITS_NONE, 0, 1, 6'd0, BITS_READ, ST_HANDLED));
		plan.push_back(row(ROW_FAULT, 1023, BITS_NONE, 63, 1, 6'd1, BITS_READ, ST_HANDLED));
		plan.push_back(row(ROW_FAULT, 5, BITS_WRITE_ONLY, 63, 1, 6'd63, BITS_WRITE_ONLY,
			ST_BAD));
		plan.push_back(row(ROW_FAULT, 1023, BITS_READ, 1, 1, 6'd1, BITS_RW, ST_HANDLED));
		plan.push_back(row(ROW_FAULT, 7, BITS_RW, 0, 1, 6'd0, BITS_RW, ST_HANDLED));
		plan.push_back(row(ROW_FAULT, 9, BITS_READ, 63, 1, 6'd63, BITS_RW, ST_HANDLED));
		plan.push_back(row(ROW_REG, CFG_FRAMES_IN_USE, 2, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 3, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 4, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 6, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_FRAMES_IN_USE, 1, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 8, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_FRAMES_IN_USE, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 10, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_FRAMES_IN_USE, 127, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 11, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_POLICY, POL_RANDOM, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_RANDOM_SEED, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_FRAMES_IN_USE, 3, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 12, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 13, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 14, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_REG, CFG_RANDOM_SEED, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 15, BITS_NONE, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_FAULT, 1023, BITS_WRITE_ONLY, 0, 1, 6'd0, BITS_WRITE_ONLY,
			ST_BAD));

		frames_pick = '{64, 3, 1, 127, 0, 64, $urandom_range(1, 64), $urandom_range(2, 16)};
		seed_pick = '{32'd1, $urandom(), 32'hFFFF_FFFF, 32'd0, $urandom(), 32'd1,
			$urandom(), $urandom()};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				write_reg(CFG_IDX_W'(plan[i].a), plan[i].b);
			end else begin
				f.page = PAGE_W'(plan[i].a);
				f.current_bits = BITS_W'(plan[i].b);
				f.current_frame = FRAME_W'(plan[i].c);
				offer_fault(f, plan[i].pin, plan[i].frame, plan[i].nbits, plan[i].st);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_POLICY, (p % 2 == 0) ? POL_FIFO : POL_RANDOM);
			write_reg(CFG_FRAMES_IN_USE, frames_pick[p]);
			write_reg(CFG_RANDOM_SEED, seed_pick[p]);
			calm = (p == 2);
			for (int k = 0; k < PER_PHASE; k++) begin
				// hold off mid-phase until everything in flight has come back
				if (p == 4 && k == PER_PHASE / 2)
					settle_idle();
				offer_fault(random_fault(), 1'b0, '0, '0, 1'b0);
			end
		end
		calm = 1'b0;

		settle_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
